### rtl/core/hrd_pkg.sv
// Package: phase codes, field widths and byte helpers for the deframer.
`default_nettype none
package hrd_pkg;
  localparam int LengthBits = 32;
  localparam int LW = LengthBits;

  localparam logic [3:0] PH_SV_SKIP   = 4'd0;
  localparam logic [3:0] PH_SV_TOKEN  = 4'd1;
  localparam logic [3:0] PH_SC_SKIP   = 4'd2;
  localparam logic [3:0] PH_SC_DIGITS = 4'd3;
  localparam logic [3:0] PH_SL_REST   = 4'd4;
  localparam logic [3:0] PH_NAME      = 4'd5;
  localparam logic [3:0] PH_CLVAL     = 4'd6;
  localparam logic [3:0] PH_TEVAL     = 4'd7;
  localparam logic [3:0] PH_HSKIP     = 4'd8;
  localparam logic [3:0] PH_ALL       = 4'd9;
  localparam logic [3:0] PH_LEN       = 4'd10;
  localparam logic [3:0] PH_CSLINE    = 4'd11;
  localparam logic [3:0] PH_CDATA     = 4'd12;
  localparam logic [3:0] PH_CCR       = 4'd13;
  localparam logic [3:0] PH_CLF       = 4'd14;
  localparam logic [3:0] PH_IGNORE    = 4'd15;

  localparam logic [3:0] E_OK         = 4'd0;
  localparam logic [3:0] E_NO_HDR     = 4'd1;
  localparam logic [3:0] E_BAD_STATUS = 4'd2;
  localparam logic [3:0] E_BAD_LEN    = 4'd3;
  localparam logic [3:0] E_TRUNC_SIZE = 4'd4;
  localparam logic [3:0] E_BAD_SIZE   = 4'd5;
  localparam logic [3:0] E_TRUNC_DATA = 4'd6;
  localparam logic [3:0] E_NO_TERM    = 4'd7;
  localparam logic [3:0] E_TRUNC_BODY = 4'd8;
  localparam logic [3:0] E_NON_2XX    = 4'd9;

  typedef struct packed {
    logic       kind;
    logic [7:0] body;
    logic [15:0] status;
    logic [3:0] err;
  } hrd_res_t;

  function automatic logic ws4(input logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0D || b == 8'h0A;
  endfunction
  function automatic logic ws6(input logic [7:0] b);
    return ws4(b) || b == 8'h0B || b == 8'h0C;
  endfunction
  function automatic logic is_dec(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction
  function automatic logic [7:0] to_lc(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
  endfunction
  // 16 means not a hex digit
  function automatic logic [4:0] hex_of(input logic [7:0] b);
    logic [7:0] c;
    c = to_lc(b);
    if (is_dec(b)) return {1'b0, b[3:0]};
    if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h57);
    return 5'd16;
  endfunction
  function automatic logic [7:0] cl_char(input logic [4:0] i);
    case (i)
      5'd0: return "c"; 5'd1: return "o"; 5'd2: return "n"; 5'd3: return "t";
      5'd4: return "e"; 5'd5: return "n"; 5'd6: return "t"; 5'd7: return "-";
      5'd8: return "l"; 5'd9: return "e"; 5'd10: return "n"; 5'd11: return "g";
      5'd12: return "t"; 5'd13: return "h";
      default: return 8'h00;
    endcase
  endfunction
  function automatic logic [7:0] te_char(input logic [4:0] i);
    case (i)
      5'd0: return "t"; 5'd1: return "r"; 5'd2: return "a"; 5'd3: return "n";
      5'd4: return "s"; 5'd5: return "f"; 5'd6: return "e"; 5'd7: return "r";
      5'd8: return "-"; 5'd9: return "e"; 5'd10: return "n"; 5'd11: return "c";
      5'd12: return "o"; 5'd13: return "d"; 5'd14: return "i"; 5'd15: return "n";
      5'd16: return "g";
      default: return 8'h00;
    endcase
  endfunction
  function automatic logic [7:0] ch_char(input logic [2:0] i);
    case (i)
      3'd0: return "c"; 3'd1: return "h"; 3'd2: return "u"; 3'd3: return "n";
      3'd4: return "k"; 3'd5: return "e"; 3'd6: return "d";
      default: return 8'h00;
    endcase
  endfunction
endpackage
`default_nettype wire

### rtl/core/hrd_parser.sv
// Parser: per-byte state update, produces up to two results per item.
`default_nettype none
module hrd_parser (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,
  input  wire logic [7:0]      b,
  input  wire logic            last,
  output hrd_pkg::hrd_res_t    res0,
  output logic                 res0_v,
  output hrd_pkg::hrd_res_t    res1,
  output logic                 res1_v
);
  import hrd_pkg::*;
  localparam logic [LW-1:0] LenMax = '1;

  logic [3:0]    ph_r, ph_nxt;
  logic [15:0]   st_r, st_nxt;
  logic [1:0]    lbt_r, lbt_nxt;
  logic [4:0]    nmp_r, nmp_nxt;
  logic [3:0]    fl_r, fl_nxt;
  logic [2:0]    cmp_r, cmp_nxt;
  logic          chk_r, chk_nxt, lp_r, lp_nxt, ds_r, ds_nxt;
  logic [LW-1:0] len_r, len_nxt, rem_r, rem_nxt;
  logic [3:0]    err_r, err_nxt;

  logic          lf_end, blank, emit;
  logic [7:0]    c;
  logic [4:0]    h;
  logic [3:0]    dv;
  logic [LW+3:0] mul10, mul16;
  logic [19:0]   sv10;
  logic [3:0]    e;
  logic [15:0]   fs;

  always_comb begin
    ph_nxt = ph_r; st_nxt = st_r; nmp_nxt = nmp_r; fl_nxt = fl_r;
    cmp_nxt = cmp_r; chk_nxt = chk_r; lp_nxt = lp_r; ds_nxt = ds_r;
    len_nxt = len_r; rem_nxt = rem_r; err_nxt = err_r;
    emit = 1'b0;
    c = to_lc(b);
    h = hex_of(b);
    dv = b[3:0];
    mul10 = {4'd0, len_r} * (LW+4)'(10) + (LW+4)'(dv);
    mul16 = {rem_r, 4'd0} + (LW+4)'(h[3:0]);
    sv10 = {4'd0, st_r} * 20'd10 + 20'(dv);
    lf_end = (b == 8'h0A) && lbt_r[0];
    blank = lf_end && lbt_r == 2'd3;
    if (b == 8'h0D) lbt_nxt = (lbt_r == 2'd2) ? 2'd3 : 2'd1;
    else lbt_nxt = lf_end ? 2'd2 : 2'd0;

    if (ph_r <= PH_SL_REST) begin
      if (lf_end) begin
        nmp_nxt = '0; fl_nxt = 4'b0011; cmp_nxt = '0; ds_nxt = 1'b0; ph_nxt = PH_NAME;
      end else begin
        case (ph_r)
          PH_SV_SKIP:  if (!ws6(b)) ph_nxt = PH_SV_TOKEN;
          PH_SV_TOKEN: if (ws6(b)) ph_nxt = PH_SC_SKIP;
          PH_SC_SKIP: begin
            if (!ws6(b)) begin
              if (is_dec(b)) begin
                st_nxt = {12'd0, dv}; ph_nxt = PH_SC_DIGITS;
              end else ph_nxt = PH_SL_REST;
            end
          end
          PH_SC_DIGITS: begin
            if (!is_dec(b)) ph_nxt = PH_SL_REST;
            else if (sv10 > 20'd65535) begin
              st_nxt = '0; ph_nxt = PH_SL_REST;
            end else st_nxt = sv10[15:0];
          end
          default: ;
        endcase
      end
    end else if (ph_r <= PH_HSKIP) begin
      if (blank) begin
        lbt_nxt = '0;
        if (st_r == 16'd0) begin
          err_nxt = E_BAD_STATUS; ph_nxt = PH_IGNORE;
        end else if (err_r != E_OK) ph_nxt = PH_IGNORE;
        else if ((st_r >= 16'd100 && st_r < 16'd200) || st_r == 16'd204 || st_r == 16'd304)
          ph_nxt = PH_IGNORE;
        else if (chk_r) begin
          ph_nxt = PH_CSLINE; nmp_nxt = '0; ds_nxt = 1'b0; rem_nxt = '0;
        end else if (lp_r) begin
          rem_nxt = len_r; ph_nxt = (len_r != '0) ? PH_LEN : PH_IGNORE;
        end else ph_nxt = PH_ALL;
      end else if (lf_end) begin
        if (ph_r == PH_CLVAL && err_r == E_OK) begin
          if (ds_r) lp_nxt = 1'b1;
          else err_nxt = E_BAD_LEN;
        end
        nmp_nxt = '0; fl_nxt = 4'b0011; cmp_nxt = '0; ds_nxt = 1'b0; ph_nxt = PH_NAME;
      end else if (ph_r == PH_NAME) begin
        if (b == 8'h3A) begin
          if (err_r != E_OK) ph_nxt = PH_HSKIP;
          else if (fl_r[0] && nmp_r == 5'd14) begin
            ph_nxt = PH_CLVAL; nmp_nxt = '0; len_nxt = '0; ds_nxt = 1'b0;
          end else if (fl_r[1] && nmp_r == 5'd17) begin
            ph_nxt = PH_TEVAL; cmp_nxt = '0;
          end else ph_nxt = PH_HSKIP;
        end else if (ws4(b)) begin
          if (fl_r[2]) fl_nxt[3] = 1'b1;
        end else begin
          if (fl_r[3]) fl_nxt[1:0] = 2'b00;
          if (nmp_r >= 5'd14 || cl_char(nmp_r) != c) fl_nxt[0] = 1'b0;
          if (nmp_r >= 5'd17 || te_char(nmp_r) != c) fl_nxt[1] = 1'b0;
          if (nmp_r < 5'd31) nmp_nxt = nmp_r + 5'd1;
          fl_nxt[2] = 1'b1;
        end
      end else if (ph_r == PH_CLVAL) begin
        if (nmp_r == 5'd0) begin
          if (!ws6(b)) begin
            if (!is_dec(b)) nmp_nxt = 5'd2;
            else begin
              len_nxt = LW'(dv); ds_nxt = 1'b1; nmp_nxt = 5'd1;
            end
          end
        end else if (nmp_r == 5'd1) begin
          if (!is_dec(b)) nmp_nxt = 5'd2;
          else if (mul10[LW+3:LW] != 4'd0) begin
            err_nxt = E_BAD_LEN; nmp_nxt = 5'd2;
          end else len_nxt = mul10[LW-1:0];
        end
      end else if (ph_r == PH_TEVAL) begin
        if (cmp_r < 3'd7) begin
          if (c == ch_char(cmp_r)) cmp_nxt = cmp_r + 3'd1;
          else cmp_nxt = (c == 8'h63) ? 3'd1 : 3'd0;
          if (cmp_r == 3'd6 && c == ch_char(cmp_r)) chk_nxt = 1'b1;
        end
      end
    end else begin
      case (ph_r)
        PH_ALL: emit = 1'b1;
        PH_LEN: begin
          emit = 1'b1;
          rem_nxt = (rem_r - LW'(1)) & LenMax;
          if (rem_nxt == '0) ph_nxt = PH_IGNORE;
        end
        PH_CSLINE: begin
          if (lf_end) begin
            if (err_r == E_BAD_SIZE || !ds_r) begin
              err_nxt = E_BAD_SIZE; ph_nxt = PH_IGNORE;
            end else if (rem_r == '0) ph_nxt = PH_IGNORE;
            else ph_nxt = PH_CDATA;
          end else if (nmp_r <= 5'd1) begin
            if (ws6(b)) nmp_nxt = 5'd1;
            else if (!h[4]) begin
              rem_nxt = LW'(h[3:0]); ds_nxt = 1'b1; nmp_nxt = 5'd2;
            end else nmp_nxt = 5'd3;
          end else if (nmp_r == 5'd2) begin
            if (h[4]) nmp_nxt = 5'd3;
            else if (mul16[LW+3:LW] != 4'd0) begin
              err_nxt = E_BAD_SIZE; nmp_nxt = 5'd3;
            end else rem_nxt = mul16[LW-1:0];
          end
        end
        PH_CDATA: begin
          emit = 1'b1;
          rem_nxt = rem_r - LW'(1);
          if (rem_nxt == '0) ph_nxt = PH_CCR;
        end
        PH_CCR: begin
          if (b == 8'h0D) ph_nxt = PH_CLF;
          else begin
            err_nxt = E_TRUNC_DATA; ph_nxt = PH_IGNORE;
          end
        end
        PH_CLF: begin
          if (b == 8'h0A) begin
            ph_nxt = PH_CSLINE; nmp_nxt = '0; ds_nxt = 1'b0; rem_nxt = '0; lbt_nxt = '0;
          end else begin
            err_nxt = E_TRUNC_DATA; ph_nxt = PH_IGNORE;
          end
        end
        default: ;
      endcase
    end

    // summary uses the state after this byte
    fs = st_nxt;
    if (ph_nxt <= PH_HSKIP) e = E_NO_HDR;
    else begin
      case (ph_nxt)
        PH_IGNORE: e = err_nxt;
        PH_LEN:    e = E_TRUNC_BODY;
        PH_CSLINE: e = (nmp_nxt == 5'd0) ? E_NO_TERM : E_TRUNC_SIZE;
        PH_CDATA, PH_CCR, PH_CLF: e = E_TRUNC_DATA;
        default:   e = E_OK;
      endcase
      if (e == E_OK && (fs < 16'd200 || fs >= 16'd300) && fs != 16'd304) e = E_NON_2XX;
    end
  end

  always_comb begin
    res0 = '{kind: 1'b0, body: b, status: 16'd0, err: E_OK};
    res1 = '{kind: 1'b1, body: 8'd0, status: (e == E_NO_HDR) ? 16'd0 : fs, err: e};
    res0_v = emit;
    res1_v = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last)) begin
      ph_r <= PH_SV_SKIP; st_r <= '0; lbt_r <= '0; nmp_r <= '0; fl_r <= '0;
      cmp_r <= '0; chk_r <= 1'b0; lp_r <= 1'b0; ds_r <= 1'b0;
      len_r <= '0; rem_r <= '0; err_r <= E_OK;
    end else if (step) begin
      ph_r <= ph_nxt; st_r <= st_nxt; lbt_r <= lbt_nxt; nmp_r <= nmp_nxt; fl_r <= fl_nxt;
      cmp_r <= cmp_nxt; chk_r <= chk_nxt; lp_r <= lp_nxt; ds_r <= ds_nxt;
      len_r <= len_nxt; rem_r <= rem_nxt; err_r <= err_nxt;
    end
  end
endmodule
`default_nettype wire

### rtl/core/hrd_out_queue.sv
// Output queue: four-entry FIFO of result items.
`default_nettype none
module hrd_out_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr0,
  input  wire hrd_pkg::hrd_res_t d0,
  input  wire logic              wr1,
  input  wire hrd_pkg::hrd_res_t d1,
  output logic                   room2,
  output logic                   out_v,
  output hrd_pkg::hrd_res_t      out_d,
  input  wire logic              rd
);
  import hrd_pkg::*;
  hrd_res_t    q_r [4];
  logic [1:0]  wp_r, rp_r;
  logic [2:0]  cnt_r;
  logic [1:0]  nw;

  assign out_v = cnt_r != 3'd0;
  assign out_d = q_r[rp_r];
  assign room2 = cnt_r <= 3'd2;
  assign nw = 2'(wr0) + 2'(wr1);

  always_ff @(posedge clk) begin
    if (wr0) q_r[wp_r] <= d0;
    if (wr1) q_r[wr0 ? wp_r + 2'd1 : wp_r] <= d1;
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r <= wp_r + nw;
      if (rd) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(nw) - 3'(rd);
    end
  end
endmodule
`default_nettype wire

### rtl/core/http_response_deframer.sv
// Top level: HTTP/1.1 response deframer, one byte per cycle while in_tready is high.
//  channel | dir | tdata                         | tuser / tlast
//  in_     | in  | [7:0] in_byte                 | tlast end_of_response
//  out_    | out | [7:0] body, [23:8] status,    | tuser result_kind,
//          |     | [27:24] error_code            | tlast last_result
// One byte per cycle while the output queue has room; each byte updates the registered
// parser state and its results land in a four-entry output queue.
// Reset: synchronous active-low; the parser also returns to reset after a summary.
// in_tready drops when fewer than two queue slots are free.
`default_nettype none
module http_response_deframer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [7:0] body_byte, [23:8] status, [27:24] error_code
  output logic             out_tuser,  // result_kind
  output logic             out_tlast
);
  import hrd_pkg::*;
  logic     step, room2, v0, v1;
  hrd_res_t r0, r1, od;

  assign step = in_tvalid && in_tready;
  assign in_tready = room2;

  hrd_parser u_parser (.clk, .rst_n, .step, .b(in_tdata), .last(in_tlast),
                       .res0(r0), .res0_v(v0), .res1(r1), .res1_v(v1));
  hrd_out_queue u_q (.clk, .rst_n, .wr0(step && v0), .d0(r0), .wr1(step && v1), .d1(r1),
                     .room2, .out_v(out_tvalid), .out_d(od), .rd(out_tvalid && out_tready));

  assign out_tdata = {4'd0, od.err, od.status, od.body};
  assign out_tuser = od.kind;
  assign out_tlast = od.kind;

  a_no_in_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !room2 |-> !step) else $error("accept without queue room");
  a_body_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[27:8] == 20'd0)) else $error("body item dirty");
  a_sum_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[27:24] <= E_NON_2XX)) else $error("bad code");
endmodule
`default_nettype wire

### verif/http_response_deframer_test.sv
// Testbench for the HTTP response deframer: directed table plus random responses, predictor-checked.
`default_nettype none
module http_response_deframer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hrd_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [7:0]  body;
    logic [15:0] status;
    logic [3:0]  err;
    logic        last;
  } res_t;

  typedef struct {
    logic [7:0] b;
    logic       eor;
    logic       has_exp;  // summary expected right here, typed in
    logic [15:0] st;
    logic [3:0] err;
  } row_t;

  localparam logic [LW-1:0] LenMax = '1;
  localparam int Stall = 2000;

  logic clk, rst_n;
  logic in_tvalid, in_tready, in_tlast;
  logic [7:0] in_tdata;
  logic out_tvalid, out_tready, out_tuser, out_tlast;
  logic [31:0] out_tdata;

  http_response_deframer u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // predictor state
  logic [3:0]    ph;
  logic [15:0]   stv;
  logic [1:0]    lbt;
  logic [4:0]    npos;
  logic [3:0]    nflg;
  logic [2:0]    cpos;
  logic          chunked, len_ok, dseen;
  logic [LW-1:0] len_v, remain;
  logic [3:0]    err_l;

  res_t pending_results[$];
  res_t typed_summary[$];
  int   fails = 0;
  int   tx_idle = 0, rx_idle = 0;
  int   quiet = 0;

  function automatic logic w4(logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0D || b == 8'h0A;
  endfunction
  function automatic logic w6(logic [7:0] b);
    return w4(b) || b == 8'h0B || b == 8'h0C;
  endfunction
  function automatic logic dec(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction
  function automatic logic [7:0] lc(logic [7:0] b);
    return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
  endfunction
  function automatic int hexv(logic [7:0] b);
    logic [7:0] c;
    c = lc(b);
    if (dec(b)) return b - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    return 16;
  endfunction

  string cl_name = "content-length";
  string te_name = "transfer-encoding";
  string ch_word = "chunked";

  task automatic clear_parser();
    ph = PH_SV_SKIP; stv = 0; lbt = 0; npos = 0; nflg = 0; cpos = 0;
    chunked = 0; len_ok = 0; len_v = 0; remain = 0; dseen = 0; err_l = E_OK;
  endtask

  task automatic start_line();
    npos = 0; nflg = 4'b0011; cpos = 0; dseen = 0; ph = PH_NAME;
  endtask

  task automatic start_size();
    ph = PH_CSLINE; npos = 0; dseen = 0; remain = 0; lbt = 0;
  endtask

  task automatic end_headers();
    lbt = 0;
    if (stv == 0) begin
      err_l = E_BAD_STATUS; ph = PH_IGNORE;
    end else if (err_l != E_OK) ph = PH_IGNORE;
    else if ((stv >= 100 && stv < 200) || stv == 204 || stv == 304) ph = PH_IGNORE;
    else if (chunked) start_size();
    else if (len_ok) begin
      remain = len_v;
      ph = (remain != 0) ? PH_LEN : PH_IGNORE;
    end else ph = PH_ALL;
  endtask

  task automatic name_step(logic [7:0] b);
    logic [7:0] c;
    if (b == ":") begin
      if (err_l != E_OK) ph = PH_HSKIP;
      else if (nflg[0] && npos == 14) begin
        ph = PH_CLVAL; npos = 0; len_v = 0; dseen = 0;
      end else if (nflg[1] && npos == 17) begin
        ph = PH_TEVAL; cpos = 0;
      end else ph = PH_HSKIP;
      return;
    end
    if (w4(b)) begin
      if (nflg[2]) nflg[3] = 1;
      return;
    end
    if (nflg[3]) nflg[1:0] = 0;
    c = lc(b);
    if (npos >= 14 || cl_name[npos] != c) nflg[0] = 0;
    if (npos >= 17 || te_name[npos] != c) nflg[1] = 0;
    if (npos < 31) npos++;
    nflg[2] = 1;
  endtask

  task automatic length_step(logic [7:0] b);
    logic [LW:0] d;
    if (npos == 0) begin
      if (w6(b)) return;
      if (!dec(b)) begin
        npos = 2; return;
      end
      len_v = LW'(b - 8'd48); dseen = 1; npos = 1;
    end else if (npos == 1) begin
      if (!dec(b)) begin
        npos = 2; return;
      end
      d = (LW+1)'(b - 8'd48);
      if ({1'b0, len_v} > ({1'b0, LenMax} - d) / 10) begin
        err_l = E_BAD_LEN; npos = 2;
      end else len_v = len_v * 10 + LW'(d);
    end
  endtask

  task automatic size_step(logic [7:0] b);
    int h;
    h = hexv(b);
    if (npos <= 1) begin
      if (w6(b)) npos = 1;
      else if (h < 16) begin
        remain = LW'(h); dseen = 1; npos = 2;
      end else npos = 3;
    end else if (npos == 2) begin
      if (h >= 16) npos = 3;
      else if ({1'b0, remain} > ({1'b0, LenMax} - h) / 16) begin
        err_l = E_BAD_SIZE; npos = 3;
      end else remain = remain * 16 + LW'(h);
    end
  endtask

  task automatic status_step(logic [7:0] b);
    int v;
    case (ph)
      PH_SV_SKIP: if (!w6(b)) ph = PH_SV_TOKEN;
      PH_SV_TOKEN: if (w6(b)) ph = PH_SC_SKIP;
      PH_SC_SKIP: begin
        if (!w6(b)) begin
          if (dec(b)) begin
            stv = 16'(b - 8'd48); ph = PH_SC_DIGITS;
          end else ph = PH_SL_REST;
        end
      end
      PH_SC_DIGITS: begin
        if (!dec(b)) ph = PH_SL_REST;
        else begin
          v = stv * 10 + (b - "0");
          if (v > 65535) begin
            stv = 0; ph = PH_SL_REST;
          end else stv = 16'(v);
        end
      end
      default: ;
    endcase
  endtask

  function automatic logic [3:0] summary_err();
    logic [3:0] e;
    if (ph <= PH_HSKIP) return E_NO_HDR;
    case (ph)
      PH_IGNORE: e = err_l;
      PH_LEN: e = E_TRUNC_BODY;
      PH_CSLINE: e = (npos == 0) ? E_NO_TERM : E_TRUNC_SIZE;
      PH_CDATA, PH_CCR, PH_CLF: e = E_TRUNC_DATA;
      default: e = E_OK;
    endcase
    if (e == E_OK && (stv < 200 || stv >= 300) && stv != 304) e = E_NON_2XX;
    return e;
  endfunction

  // advance the predictor by one byte and queue what it produces
  task automatic deframe_byte(logic [7:0] b, logic eor);
    logic lf_end, blank, emit;
    logic [3:0] e;
    res_t r;
    lf_end = (b == 8'h0A) && lbt[0];
    blank = lf_end && lbt == 3;
    emit = 0;
    if (b == 8'h0D) lbt = (lbt == 2) ? 2'd3 : 2'd1;
    else lbt = lf_end ? 2'd2 : 2'd0;
    if (ph <= PH_SL_REST) begin
      if (lf_end) start_line();
      else status_step(b);
    end else if (ph <= PH_HSKIP) begin
      if (blank) end_headers();
      else if (lf_end) begin
        if (ph == PH_CLVAL && err_l == E_OK) begin
          if (dseen) len_ok = 1;
          else err_l = E_BAD_LEN;
        end
        start_line();
      end else if (ph == PH_NAME) name_step(b);
      else if (ph == PH_CLVAL) length_step(b);
      else if (ph == PH_TEVAL) begin
        if (cpos < 7) begin
          if (lc(b) == ch_word[cpos]) cpos++;
          else cpos = (lc(b) == "c") ? 3'd1 : 3'd0;
          if (cpos >= 7) chunked = 1;
        end
      end
    end else begin
      case (ph)
        PH_ALL: emit = 1;
        PH_LEN: begin
          emit = 1; remain = remain - 1;
          if (remain == 0) ph = PH_IGNORE;
        end
        PH_CSLINE: begin
          if (lf_end) begin
            if (err_l == E_BAD_SIZE || !dseen) begin
              err_l = E_BAD_SIZE; ph = PH_IGNORE;
            end else if (remain == 0) ph = PH_IGNORE;
            else ph = PH_CDATA;
          end else size_step(b);
        end
        PH_CDATA: begin
          emit = 1; remain = remain - 1;
          if (remain == 0) ph = PH_CCR;
        end
        PH_CCR: begin
          if (b == 8'h0D) ph = PH_CLF;
          else begin
            err_l = E_TRUNC_DATA; ph = PH_IGNORE;
          end
        end
        PH_CLF: begin
          if (b == 8'h0A) start_size();
          else begin
            err_l = E_TRUNC_DATA; ph = PH_IGNORE;
          end
        end
        default: ;
      endcase
    end
    if (emit) begin
      r = '{kind: 1'b0, body: b, status: 16'd0, err: E_OK, last: 1'b0};
      pending_results.push_back(r);
    end
    if (eor) begin
      e = summary_err();
      r = '{kind: 1'b1, body: 8'd0, status: (e == E_NO_HDR) ? 16'd0 : stv, err: e, last: 1'b1};
      pending_results.push_back(r);
      clear_parser();
    end
  endtask

  // drive one byte and wait for it to be taken; tvalid stays up until the next
  // idle cycle or drain
  task automatic send_byte(logic [7:0] b, logic eor);
    while (tx_idle > 0 && $urandom_range(99) < tx_idle) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1; in_tdata <= b; in_tlast <= eor;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    deframe_byte(b, eor);
  endtask

  task automatic send_text(string s, logic eor_at_end);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], eor_at_end && i == s.len() - 1);
  endtask

  // output side: check against the oldest expectation
  always @(posedge clk) begin
    res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{kind: out_tuser, body: out_tdata[7:0], status: out_tdata[23:8],
              err: out_tdata[27:24], last: out_tlast};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, got);
        fails++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          $display("%0t: result mismatch, expected %h, got %h", $time, want, got);
          fails++;
        end
        if (got.kind && typed_summary.size() > 0) begin
          want = typed_summary.pop_front();
          if (got.status !== want.status || got.err !== want.err) begin
            $display("%0t: summary mismatch, expected %h, got %h", $time, want, got);
            fails++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    out_tready <= (rx_idle == 0) || ($urandom_range(99) >= rx_idle);
  end

  // watchdog: cycles with nothing accepted
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > Stall) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic string rand_case(string s);
    string t;
    t = s;
    for (int i = 0; i < t.len(); i++)
      if ($urandom_range(1) && t[i] >= "a" && t[i] <= "z") t[i] = t[i] - 8'd32;
    return t;
  endfunction

  // one random response, mostly well formed
  task automatic random_response();
    int kind, n, st;
    string s, body;
    logic [7:0] b;
    st = ($urandom_range(3) == 0) ? $urandom_range(99, 599) : 200;
    if ($urandom_range(19) == 0) st = 304;
    if ($urandom_range(19) == 0) st = 204;
    s = $sformatf("%sHTTP/1.1 %0d OK\r\n", ($urandom_range(9) == 0) ? " \t" : "", st);
    kind = $urandom_range(9);
    n = $urandom_range(0, 12);
    if (kind < 4) s = {s, rand_case("content-length"), ($urandom_range(1) ? " " : ""),
                       $sformatf(": %0d\r\n", n)};
    else if (kind < 8) s = {s, rand_case("Transfer-Encoding"), ": gzip, ",
                            rand_case("chunked"), "\r\n"};
    if ($urandom_range(2) == 0) s = {s, "X-Other: v\r\n"};
    s = {s, "\r\n"};
    send_text(s, 0);
    if (kind >= 4 && kind < 8) begin
      for (int c = 0; c < $urandom_range(1, 3); c++) begin
        n = $urandom_range(1, 10);
        send_text($sformatf("%0h%s\r\n", n, ($urandom_range(3) == 0) ? ";x=1" : ""), 0);
        for (int i = 0; i < n; i++) send_byte(8'($urandom_range(255)), 0);
        send_text("\r\n", 0);
      end
      if ($urandom_range(4) != 0) send_text("0\r\n", 0);
    end else begin
      for (int i = 0; i < n + $urandom_range(0, 2); i++) send_byte(8'($urandom_range(255)), 0);
    end
    b = 8'($urandom_range(255));
    send_byte(b, 1);
  endtask

  row_t plan[$];
  int sent;

  task automatic add_text(string s, logic eor, logic [15:0] st, logic [3:0] e, logic typed);
    row_t r;
    for (int i = 0; i < s.len(); i++) begin
      r.b = s[i]; r.eor = eor && i == s.len() - 1;
      r.has_exp = typed && r.eor; r.st = st; r.err = e;
      plan.push_back(r);
    end
  endtask

  initial begin
    rst_n = 0; in_tvalid = 0; in_tdata = 0; in_tlast = 0;
    clear_parser();
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed table
    add_text("\xff", 1, 16'd0, E_NO_HDR, 1);
    add_text("H 65536\r\n\r\n", 1, 16'd0, E_BAD_STATUS, 1);
    add_text("H 200\r\nContent-Length: 99999999999\r\n\r\n", 1, 16'd200, E_BAD_LEN, 1);
    add_text("H 200\r\nTransfer-Encoding: chunked\r\n\r\nff", 1, 16'd200, E_TRUNC_SIZE, 1);
    add_text("H 200\r\nTransfer-Encoding: chunked\r\n\r\n0x1\r\nz", 1, 16'd200, E_OK, 0);
    add_text("H 200\r\nTransfer-Encoding: CHUNKED\r\n\r\nG\r\n", 1, 16'd200, E_BAD_SIZE, 1);
    add_text("H 200\r\ntransfer-encoding: chunked\r\n\r\n2\r\nab", 1, 16'd200, E_TRUNC_DATA, 1);
    add_text("H 200\r\ntransfer-encoding: chunked\r\n\r\n1;e\r\nq\r\n", 1, 16'd200,
             E_NO_TERM, 1);
    add_text("H 200\r\n Content-Length :3\r\n\r\nx", 1, 16'd200, E_TRUNC_BODY, 1);
    add_text("H 404\r\n\r\n\x00", 1, 16'd404, E_NON_2XX, 1);
    add_text("H 304\r\n\r\nz", 1, 16'd304, E_OK, 1);
    add_text("H 200\r\nContent-Length: -1\r\n\r\n", 1, 16'd200, E_BAD_LEN, 1);
    add_text("H 200\r\nContent-Length: 2\r\ncontent-length: 1\r\n\r\nAB", 1, 16'd200,
             E_OK, 1);
    foreach (plan[i]) begin
      if (plan[i].has_exp)
        typed_summary.push_back('{kind: 1'b1, body: 8'd0, status: plan[i].st,
                                  err: plan[i].err, last: 1'b1});
      else if (plan[i].eor)
        typed_summary.push_back('{kind: 1'b1, body: 8'd0, status: 16'd200,
                                  err: E_OK, last: 1'b1});
      send_byte(plan[i].b, plan[i].eor);
    end
    drain();
    typed_summary.delete();

    // random part, three idling phases
    for (int p = 0; p < 3; p++) begin
      tx_idle = (p == 0) ? 21 : (p == 1) ? 86 : 0;
      rx_idle = (p == 0) ? 86 : (p == 1) ? 21 : 0;
      sent = 0;
      while (sent < 4) begin
        random_response();
        sent++;
        if ($urandom_range(7) == 0) drain();
        if ($urandom_range(9) == 0) begin
          // noise: random bytes as a response
          for (int i = 0; i < $urandom_range(1, 8); i++) send_byte(8'($urandom_range(255)), 0);
          send_byte(8'($urandom_range(255)), 1);
        end
      end
      drain();
    end
    tx_idle = 0; rx_idle = 0;
    for (int i = 0; i < 2; i++) random_response();

    drain();
    repeat (20) @(posedge clk);
    if (fails == 0 && pending_results.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
`default_nettype wire

### sim.f
rtl/core/hrd_pkg.sv
rtl/core/hrd_parser.sv
rtl/core/hrd_out_queue.sv
rtl/core/http_response_deframer.sv
verif/http_response_deframer_test.sv
